### sv/pfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared sizes, codes and types of the paged frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

    // sizes of the managed stores
    localparam int MAX_FRAMES  = 64;
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CMDQ_DEPTH  = 2;

    localparam int FRAME_AW = $clog2(MAX_FRAMES);
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_CW   = $clog2(MAX_RESULTS + 1);
    localparam int CMDQ_AW  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW  = $clog2(CMDQ_DEPTH + 1);

    // field widths
    localparam int PID_W  = 8;
    localparam int CNT_W  = 7;
    localparam int KIND_W = 2;

    // command codes between front and back
    localparam logic [1:0] CMD_FREE   = 2'd0;
    localparam logic [1:0] CMD_ARRIVE = 2'd1;
    localparam logic [1:0] CMD_RETRY  = 2'd2;

    // result event kinds
    localparam logic [KIND_W-1:0] EV_ADMIT = 2'd0;
    localparam logic [KIND_W-1:0] EV_NONE  = 2'd1;
    localparam logic [KIND_W-1:0] EV_FREED = 2'd2;
    localparam logic [KIND_W-1:0] EV_DROP  = 2'd3;

    // classified command
    typedef struct packed {
        logic [1:0]       code;
        logic [PID_W-1:0] pid;
        logic [CNT_W-1:0] pages;
    } t_cmd;

endpackage
`default_nettype wire

### sv/pfa_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_front
// Accepts input transactions and classifies them into commands.
// ----------------------------------------------------------------------------
module pfa_front (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_operation,
    input  wire logic [pfa_pkg::PID_W-1:0] i_process_id,
    input  wire logic [pfa_pkg::CNT_W-1:0] i_page_count,
    output logic                         o_push_valid,
    input  wire logic                    i_push_ready,
    output pfa_pkg::t_cmd                o_push_cmd
);

    logic          r_valid;
    pfa_pkg::t_cmd r_cmd;
    pfa_pkg::t_cmd n_cmd;
    logic          w_accept;

    assign o_in_ready   = !r_valid || i_push_ready;
    assign w_accept     = i_in_valid && o_in_ready;
    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

    // classify: completion, arrival with an id, arrival that only retries
    always_comb begin
        n_cmd.pid   = i_process_id;
        n_cmd.pages = i_page_count;
        if (i_operation) begin
            n_cmd.code = pfa_pkg::CMD_FREE;
        end else if (i_process_id == '0) begin
            n_cmd.code = pfa_pkg::CMD_RETRY;
        end else begin
            n_cmd.code = pfa_pkg::CMD_ARRIVE;
        end
    end

    // holding stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule
`default_nettype wire

### sv/pfa_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_cmd_queue
// Short command FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module pfa_cmd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  wire pfa_pkg::t_cmd  i_push_cmd,
    output logic                o_pop_valid,
    input  wire logic           i_pop,
    output pfa_pkg::t_cmd       o_pop_cmd
);

    pfa_pkg::t_cmd                r_mem [pfa_pkg::CMDQ_DEPTH];
    logic [pfa_pkg::CMDQ_AW-1:0]  r_wp;
    logic [pfa_pkg::CMDQ_AW-1:0]  r_rp;
    logic [pfa_pkg::CMDQ_CW-1:0]  r_cnt;
    logic                         w_push;
    logic                         w_pop;

    assign o_push_ready = r_cnt != pfa_pkg::CMDQ_CW'(pfa_pkg::CMDQ_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_cmd    = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_cmd;
        end
    end

endmodule
`default_nettype wire

### sv/pfa_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_back
// Executes commands: wait queue, frame table scans and the result register.
// ----------------------------------------------------------------------------
module pfa_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [pfa_pkg::CNT_W-1:0]  i_cfg_data,
    input  wire logic                       i_cmd_valid,
    output logic                            o_cmd_pop,
    input  wire pfa_pkg::t_cmd              i_cmd,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [pfa_pkg::KIND_W-1:0]      o_event_kind,
    output logic [pfa_pkg::PID_W-1:0]       o_event_pid,
    output logic [pfa_pkg::CNT_W-1:0]       o_frames_moved,
    output logic [pfa_pkg::CNT_W-1:0]       o_free_frames,
    output logic                            o_last
);

    localparam int FAW = pfa_pkg::FRAME_AW;
    localparam int QAW = pfa_pkg::QUEUE_AW;
    localparam int QFW = pfa_pkg::QFILL_W;
    localparam int KW  = pfa_pkg::RES_CW;
    localparam int PW  = pfa_pkg::PID_W;
    localparam int CW  = pfa_pkg::CNT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FDONE = 3'd3;
    localparam logic [2:0] S_ADONE = 3'd4;

    // frames actually managed
    function automatic logic [CW-1:0] managed(input logic [CW-1:0] fiu);
        managed = (fiu > CW'(pfa_pkg::MAX_FRAMES)) ? CW'(pfa_pkg::MAX_FRAMES) : fiu;
    endfunction

    // control registers
    logic [2:0]     r_state, n_state;
    logic [CW-1:0]  r_fiu, n_fiu;
    logic [CW-1:0]  r_fc, n_fc;
    logic [QAW-1:0] r_qhead, n_qhead;
    logic [QFW-1:0] r_qfill, n_qfill;
    logic [KW-1:0]  r_k, n_k;
    logic           r_mode_free, n_mode_free;
    logic [PW-1:0]  r_pid, n_pid;
    logic [CW-1:0]  r_left, n_left;
    logic [CW-1:0]  r_moved, n_moved;
    logic [CW-1:0]  r_idx, n_idx;
    logic           r_pend, n_pend;

    // wait queue, undefined until written
    logic [PW-1:0]  r_qpid   [pfa_pkg::QUEUE_DEPTH];
    logic [CW-1:0]  r_qpages [pfa_pkg::QUEUE_DEPTH];
    logic           w_q_we;
    logic [QAW-1:0] w_q_wa;

    // frame table with per-entry valid bits
    logic [PW-1:0]               m_owner [pfa_pkg::MAX_FRAMES];
    logic [pfa_pkg::MAX_FRAMES-1:0] r_fvld;
    logic [PW-1:0]               r_rd_data;
    logic                        r_rd_vld;
    logic                        w_rd_en;
    logic [FAW-1:0]              w_ra;
    logic                        w_we;
    logic [FAW-1:0]              w_wa;
    logic [PW-1:0]               w_wd;
    logic [FAW-1:0]              r_pend_addr;

    // result register
    logic                        r_out_valid;
    logic [pfa_pkg::KIND_W-1:0]  r_ev_kind;
    logic [PW-1:0]               r_ev_pid;
    logic [CW-1:0]               r_ev_moved;
    logic [CW-1:0]               r_ev_free;
    logic                        r_ev_last;
    logic                        w_emit;
    logic [pfa_pkg::KIND_W-1:0]  w_ev_kind;
    logic [PW-1:0]               w_ev_pid;
    logic [CW-1:0]               w_ev_moved;
    logic [CW-1:0]               w_ev_free;
    logic                        w_ev_last;

    // helpers
    logic [CW-1:0] w_n;
    logic          w_emit_ok;
    logic [PW-1:0] w_rd_owner;
    logic          w_hit;
    logic [CW-1:0] w_left_next;
    logic [CW-1:0] w_head_pages;
    logic          w_more;

    // frame count writes are taken only between commands
    assign o_cfg_ready    = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_ev_kind;
    assign o_event_pid    = r_ev_pid;
    assign o_frames_moved = r_ev_moved;
    assign o_free_frames  = r_ev_free;
    assign o_last         = r_ev_last;

    assign w_n          = managed(r_fiu);
    assign w_emit_ok    = !r_out_valid || i_out_ready;
    assign w_rd_owner   = r_rd_vld ? r_rd_data : '0;
    assign w_head_pages = r_qpages[r_qhead];
    assign w_hit        = r_pend && (r_mode_free ? (w_rd_owner == r_pid)
                                                 : (w_rd_owner == '0 && r_left != '0));
    assign w_left_next  = (!r_mode_free && w_hit) ? r_left - 1'b1 : r_left;
    assign w_more       = (r_qfill != '0) && ((r_k + 1'b1) < KW'(pfa_pkg::MAX_RESULTS))
                          && (w_head_pages <= r_fc);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_fiu       = r_fiu;
        n_fc        = r_fc;
        n_qhead     = r_qhead;
        n_qfill     = r_qfill;
        n_k         = r_k;
        n_mode_free = r_mode_free;
        n_pid       = r_pid;
        n_left      = r_left;
        n_moved     = r_moved;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        o_cmd_pop   = 1'b0;
        w_q_we      = 1'b0;
        w_q_wa      = r_qhead + r_qfill[QAW-1:0];
        w_rd_en     = 1'b0;
        w_ra        = r_idx[FAW-1:0];
        w_we        = 1'b0;
        w_wa        = r_pend_addr;
        w_wd        = r_mode_free ? '0 : r_pid;
        w_emit      = 1'b0;
        w_ev_kind   = pfa_pkg::EV_NONE;
        w_ev_pid    = '0;
        w_ev_moved  = '0;
        w_ev_free   = r_fc;
        w_ev_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    // restart with a new frame count
                    n_fiu   = i_cfg_data;
                    n_fc    = managed(i_cfg_data);
                    n_qhead = '0;
                    n_qfill = '0;
                end else if (i_cmd_valid && w_emit_ok) begin
                    o_cmd_pop = 1'b1;
                    n_k       = '0;
                    n_idx     = '0;
                    unique case (i_cmd.code)
                        pfa_pkg::CMD_FREE: begin
                            if (i_cmd.pid == '0) begin
                                w_emit    = 1'b1;
                                w_ev_kind = pfa_pkg::EV_FREED;
                            end else begin
                                n_mode_free = 1'b1;
                                n_pid       = i_cmd.pid;
                                n_moved     = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        pfa_pkg::CMD_ARRIVE: begin
                            if (r_qfill >= QFW'(pfa_pkg::QUEUE_DEPTH)) begin
                                w_emit    = 1'b1;
                                w_ev_kind = pfa_pkg::EV_DROP;
                            end else begin
                                w_q_we  = 1'b1;
                                n_qfill = r_qfill + 1'b1;
                                n_state = S_CHECK;
                            end
                        end
                        pfa_pkg::CMD_RETRY: begin
                            n_state = S_CHECK;
                        end
                        default: begin
                            n_state = S_CHECK;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if ((r_qfill != '0) && (r_k < KW'(pfa_pkg::MAX_RESULTS))
                    && (w_head_pages <= r_fc)) begin
                    // admit the head and scan for free frames
                    n_mode_free = 1'b0;
                    n_pid       = r_qpid[r_qhead];
                    n_moved     = w_head_pages;
                    n_left      = w_head_pages;
                    n_fc        = r_fc - w_head_pages;
                    n_qhead     = r_qhead + 1'b1;
                    n_qfill     = r_qfill - 1'b1;
                    n_idx       = '0;
                    n_state     = S_SCAN;
                end else if (w_emit_ok) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                // one frame a cycle through the registered read port
                w_we   = w_hit;
                n_left = w_left_next;
                if (r_mode_free && w_hit) begin
                    n_moved = r_moved + 1'b1;
                end
                if ((r_idx < w_n) && (r_mode_free || w_left_next != '0)) begin
                    w_rd_en = 1'b1;
                    n_idx   = r_idx + 1'b1;
                    n_pend  = 1'b1;
                end else begin
                    n_state = r_mode_free ? S_FDONE : S_ADONE;
                end
            end
            S_FDONE: begin
                if (w_emit_ok) begin
                    w_emit     = 1'b1;
                    w_ev_kind  = pfa_pkg::EV_FREED;
                    w_ev_pid   = r_pid;
                    w_ev_moved = r_moved;
                    w_ev_free  = r_fc + r_moved;
                    n_fc       = r_fc + r_moved;
                    n_state    = S_IDLE;
                end
            end
            S_ADONE: begin
                if (w_emit_ok) begin
                    w_emit     = 1'b1;
                    w_ev_kind  = pfa_pkg::EV_ADMIT;
                    w_ev_pid   = r_pid;
                    w_ev_moved = r_moved;
                    w_ev_last  = !w_more;
                    n_k        = r_k + 1'b1;
                    n_state    = w_more ? S_CHECK : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fiu       <= CW'(pfa_pkg::MAX_FRAMES);
            r_fc        <= CW'(pfa_pkg::MAX_FRAMES);
            r_qhead     <= '0;
            r_qfill     <= '0;
            r_k         <= '0;
            r_mode_free <= 1'b0;
            r_left      <= '0;
            r_moved     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fiu       <= n_fiu;
            r_fc        <= n_fc;
            r_qhead     <= n_qhead;
            r_qfill     <= n_qfill;
            r_k         <= n_k;
            r_mode_free <= n_mode_free;
            r_left      <= n_left;
            r_moved     <= n_moved;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pid <= n_pid;
        if (w_rd_en) begin
            r_pend_addr <= w_ra;
        end
    end

    // wait queue storage
    always_ff @(posedge i_clk) begin
        if (w_q_we) begin
            r_qpid[w_q_wa]   <= i_cmd.pid;
            r_qpages[w_q_wa] <= i_cmd.pages;
        end
    end

    // frame table memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            m_owner[w_wa] <= w_wd;
        end
        if (w_rd_en) begin
            r_rd_data <= m_owner[w_ra];
        end
    end

    // frame valid bits, cleared by reset and restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvld   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (r_state == S_IDLE && i_cfg_valid) begin
                r_fvld <= '0;
            end else if (w_we) begin
                r_fvld[w_wa] <= 1'b1;
            end
            if (w_rd_en) begin
                r_rd_vld <= r_fvld[w_ra];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_ev_kind  <= w_ev_kind;
            r_ev_pid   <= w_ev_pid;
            r_ev_moved <= w_ev_moved;
            r_ev_free  <= w_ev_free;
            r_ev_last  <= w_ev_last;
        end
    end

endmodule
`default_nettype wire

### sv/paged_frame_allocator_fifo_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// paged_frame_allocator_fifo_unit
// Page frame allocator with a FIFO wait queue of arriving processes.
// ----------------------------------------------------------------------------
// An arrival queues a process id and page count, then admits queued heads in
// order while each fits the free count, giving the lowest free frames and one
// result per admitted process (kind 1 when none is admitted, kind 3 when the
// queue is full). A completion frees every frame of its id and gives one
// result. The frame table is scanned one entry a cycle through its registered
// read port. An item passes the holding stage and the two-entry command queue
// before the back end sees it, and a result that is not taken holds the back
// end until it is. A frame count write restarts the allocator (valid bits
// clear the frame table at once) and is taken only while the back end
// is idle.
// ----------------------------------------------------------------------------
module paged_frame_allocator_fifo_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_operation,
    input  wire logic [pfa_pkg::PID_W-1:0]   i_process_id,
    input  wire logic [pfa_pkg::CNT_W-1:0]   i_page_count,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [pfa_pkg::KIND_W-1:0]       o_event_kind,
    output logic [pfa_pkg::PID_W-1:0]        o_event_pid,
    output logic [pfa_pkg::CNT_W-1:0]        o_frames_moved,
    output logic [pfa_pkg::CNT_W-1:0]        o_free_frames,
    output logic                             o_last,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [pfa_pkg::CNT_W-1:0]   i_cfg_data
);

    logic          w_push_valid;
    logic          w_push_ready;
    pfa_pkg::t_cmd w_push_cmd;
    logic          w_pop_valid;
    logic          w_pop;
    pfa_pkg::t_cmd w_pop_cmd;

    // accept and classify
    pfa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_process_id (i_process_id),
        .i_page_count (i_page_count),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_cmd   (w_push_cmd)
    );

    // command queue
    pfa_cmd_queue u_cmdq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_cmd   (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop        (w_pop),
        .o_pop_cmd    (w_pop_cmd)
    );

    // execution
    pfa_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_cmd_valid    (w_pop_valid),
        .o_cmd_pop      (w_pop),
        .i_cmd          (w_pop_cmd),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_kind   (o_event_kind),
        .o_event_pid    (o_event_pid),
        .o_frames_moved (o_frames_moved),
        .o_free_frames  (o_free_frames),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire

### sv/pfa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_checker
// Port-level checks of the frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pfa_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [pfa_pkg::KIND_W-1:0]  o_event_kind,
    input wire logic [pfa_pkg::PID_W-1:0]   o_event_pid,
    input wire logic [pfa_pkg::CNT_W-1:0]   o_frames_moved,
    input wire logic [pfa_pkg::CNT_W-1:0]   o_free_frames,
    input wire logic                        o_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable({o_event_kind, o_event_pid, o_frames_moved, o_free_frames, o_last}))
        else $error("stalled result changed");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // drop and idle events carry no process and close the transaction
    a_empty_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_kind == pfa_pkg::EV_DROP || o_event_kind == pfa_pkg::EV_NONE)
            |-> o_event_pid == '0 && o_frames_moved == '0 && o_last)
        else $error("empty event carries data");

    // a free event is always the final result
    a_free_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind == pfa_pkg::EV_FREED |-> o_last)
        else $error("free event not last");

    // free count and frames moved never exceed the table
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_free_frames <= pfa_pkg::CNT_W'(pfa_pkg::MAX_FRAMES)
            && o_frames_moved <= pfa_pkg::CNT_W'(pfa_pkg::MAX_FRAMES))
        else $error("frame count out of range");

endmodule

bind paged_frame_allocator_fifo_unit pfa_checker u_pfa_checker (.*);
`default_nettype wire

### dv/paged_frame_allocator_fifo_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_frame_allocator_fifo_unit_tb
// Self-checking bench for the paged frame allocator with its wait queue.
// ----------------------------------------------------------------------------
// A queue of requests is filled by the sequencer and drained by a clocked
// driver. Each accepted transaction is run through a behavioural copy of the
// frame table and wait queue, and the events it must raise are queued. A
// clocked monitor compares each event with the oldest one queued. The run
// starts with hand-picked requests, then goes through random phases at
// several frame counts, with idle patterns on both sides, one long output
// hold-off and sender pauses until all events are back.
// ----------------------------------------------------------------------------
module paged_frame_allocator_fifo_unit_tb;

    localparam logic OP_ARRIVE   = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    localparam int SETTLE_CYCLES   = 100;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int POOL_SIZE       = 12;
    localparam int CHUNK_ITEMS     = 25;

    typedef struct packed {
        logic                      op;
        logic [pfa_pkg::PID_W-1:0] pid;
        logic [pfa_pkg::CNT_W-1:0] pages;
    } t_alloc_request;

    typedef struct packed {
        logic [pfa_pkg::KIND_W-1:0] kind;
        logic [pfa_pkg::PID_W-1:0]  pid;
        logic [pfa_pkg::CNT_W-1:0]  moved;
        logic [pfa_pkg::CNT_W-1:0]  free_after;
        logic                       last;
    } t_frame_event;

    // bench signals, all known from time zero
    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      in_valid     = 1'b0;
    logic                      in_operation = OP_ARRIVE;
    logic [pfa_pkg::PID_W-1:0] in_pid       = '0;
    logic [pfa_pkg::CNT_W-1:0] in_pages     = '0;
    logic                      out_ready    = 1'b0;
    logic                      cfg_valid    = 1'b0;
    logic [pfa_pkg::CNT_W-1:0] cfg_data     = '0;
    logic                      hold_off_go  = 1'b0;

    logic                       in_ready;
    logic                       out_valid;
    logic [pfa_pkg::KIND_W-1:0] ev_kind;
    logic [pfa_pkg::PID_W-1:0]  ev_pid;
    logic [pfa_pkg::CNT_W-1:0]  ev_moved;
    logic [pfa_pkg::CNT_W-1:0]  ev_free;
    logic                       ev_last;
    logic                       cfg_ready;

    // request backlog and expected events
    t_alloc_request request_backlog[$];
    t_frame_event   frame_events_due[$];
    int             items_queued  = 0;
    int             items_taken   = 0;
    int             failures      = 0;
    int             send_idle_pct = 31;
    int             recv_idle_pct = 63;
    int             hold_left     = 0;
    logic           hold_taken    = 1'b0;
    logic [pfa_pkg::PID_W-1:0] pid_pool [POOL_SIZE];

    // behavioural copy of the allocator state
    logic [pfa_pkg::PID_W-1:0] frame_holder [pfa_pkg::MAX_FRAMES];
    logic [pfa_pkg::PID_W-1:0] wait_pid     [pfa_pkg::QUEUE_DEPTH];
    logic [pfa_pkg::CNT_W-1:0] wait_pages   [pfa_pkg::QUEUE_DEPTH];
    int                        wait_head;
    int                        wait_fill;
    int                        free_left;
    int                        frames_managed;

    paged_frame_allocator_fifo_unit i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_operation    (in_operation),
        .i_process_id   (in_pid),
        .i_page_count   (in_pages),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_event_kind   (ev_kind),
        .o_event_pid    (ev_pid),
        .o_frames_moved (ev_moved),
        .o_free_frames  (ev_free),
        .o_last         (ev_last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    // clock
    always #4 clk = ~clk;

    // restart: every frame free, queue empty
    function automatic void clear_allocator(input logic [pfa_pkg::CNT_W-1:0] count);
        int idx;
        for (idx = 0; idx < pfa_pkg::MAX_FRAMES; idx++) frame_holder[idx] = '0;
        wait_head      = 0;
        wait_fill      = 0;
        frames_managed = (count > pfa_pkg::MAX_FRAMES) ? pfa_pkg::MAX_FRAMES : int'(count);
        free_left      = frames_managed;
    endfunction

    function automatic void note_event(input logic [pfa_pkg::KIND_W-1:0] kind,
                                       input int pid, input int moved,
                                       input logic last);
        t_frame_event ev;
        ev.kind       = kind;
        ev.pid        = pid[pfa_pkg::PID_W-1:0];
        ev.moved      = moved[pfa_pkg::CNT_W-1:0];
        ev.free_after = free_left[pfa_pkg::CNT_W-1:0];
        ev.last       = last;
        frame_events_due.insert(frame_events_due.size(), ev);
    endfunction

    // events raised by one accepted transaction
    task automatic allocate_frames(input logic op, input logic [pfa_pkg::PID_W-1:0] pid,
                                   input logic [pfa_pkg::CNT_W-1:0] pages);
        int idx;
        int freed;
        int admitted;
        int need;
        int left;
        int owner;
        t_frame_event ev;
        freed    = 0;
        admitted = 0;
        if (op == OP_COMPLETE) begin
            if (pid != 0) begin
                for (idx = 0; idx < frames_managed; idx++) begin
                    if (frame_holder[idx] == pid) begin
                        frame_holder[idx] = '0;
                        freed++;
                    end
                end
            end
            free_left += freed;
            note_event(pfa_pkg::EV_FREED, pid, freed, 1'b1);
            return;
        end
        // id zero is never queued, but the queue is still retried
        if (pid != 0) begin
            if (wait_fill >= pfa_pkg::QUEUE_DEPTH) begin
                note_event(pfa_pkg::EV_DROP, 0, 0, 1'b1);
                return;
            end
            wait_pid[(wait_head + wait_fill) % pfa_pkg::QUEUE_DEPTH]   = pid;
            wait_pages[(wait_head + wait_fill) % pfa_pkg::QUEUE_DEPTH] = pages;
            wait_fill++;
        end
        // admit heads in order while they fit
        while (wait_fill > 0 && admitted < pfa_pkg::MAX_RESULTS) begin
            need = int'(wait_pages[wait_head]);
            if (need > free_left) break;
            owner     = int'(wait_pid[wait_head]);
            wait_head = (wait_head + 1) % pfa_pkg::QUEUE_DEPTH;
            wait_fill--;
            left = need;
            for (idx = 0; idx < frames_managed && left > 0; idx++) begin
                if (frame_holder[idx] == '0) begin
                    frame_holder[idx] = owner[pfa_pkg::PID_W-1:0];
                    left--;
                end
            end
            free_left -= need;
            note_event(pfa_pkg::EV_ADMIT, owner, need, 1'b0);
            admitted++;
        end
        if (admitted == 0) begin
            note_event(pfa_pkg::EV_NONE, 0, 0, 1'b1);
        end else begin
            ev      = frame_events_due.pop_back();
            ev.last = 1'b1;
            frame_events_due.insert(frame_events_due.size(), ev);
        end
    endtask

    // request driver
    always @(posedge clk) begin
        t_alloc_request req;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                allocate_frames(in_operation, in_pid, in_pages);
                items_taken <= items_taken + 1;
            end
            if (!in_valid || in_ready) begin
                if (request_backlog.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    req          = request_backlog.pop_front();
                    in_valid     <= 1'b1;
                    in_operation <= req.op;
                    in_pid       <= req.pid;
                    in_pages     <= req.pages;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output ready, with one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_off_go && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_OFF_CYCLES;
            out_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // event monitor
    always @(posedge clk) begin
        t_frame_event exp_ev;
        if (rst_n && out_valid && out_ready) begin
            if (frame_events_due.size() == 0) begin
                $error("unexpected event kind %0d pid %0d", ev_kind, ev_pid);
                failures++;
            end else begin
                exp_ev = frame_events_due.pop_front();
                if (ev_kind !== exp_ev.kind) begin
                    $error("event_kind expected %0d got %0d", exp_ev.kind, ev_kind);
                    failures++;
                end
                if (ev_pid !== exp_ev.pid) begin
                    $error("event_pid expected %0d got %0d", exp_ev.pid, ev_pid);
                    failures++;
                end
                if (ev_moved !== exp_ev.moved) begin
                    $error("frames_moved expected %0d got %0d", exp_ev.moved, ev_moved);
                    failures++;
                end
                if (ev_free !== exp_ev.free_after) begin
                    $error("free_frames expected %0d got %0d", exp_ev.free_after,
                           ev_free);
                    failures++;
                end
                if (ev_last !== exp_ev.last) begin
                    $error("last expected %0d got %0d", exp_ev.last, ev_last);
                    failures++;
                end
            end
        end
    end

    task automatic queue_request(input logic op, input int pid, input int pages);
        t_alloc_request req;
        req.op    = op;
        req.pid   = pid[pfa_pkg::PID_W-1:0];
        req.pages = pages[pfa_pkg::CNT_W-1:0];
        request_backlog.insert(request_backlog.size(), req);
        items_queued++;
    endtask

    // wait until every transaction is taken and every event is back
    task automatic wait_drained();
        while (items_taken != items_queued || frame_events_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame_count(input int count);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= count[pfa_pkg::CNT_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        clear_allocator(count[pfa_pkg::CNT_W-1:0]);
    endtask

    // mostly a small set of live ids, so completions hit owned frames
    task automatic run_random(input int count, input int frames);
        int n;
        int r;
        int pid;
        int pages;
        logic op;
        for (n = 0; n < POOL_SIZE; n++) pid_pool[n] = $urandom_range(1, 255);
        for (n = 0; n < count; n++) begin
            op = ($urandom_range(99) < 55) ? OP_ARRIVE : OP_COMPLETE;
            r  = $urandom_range(99);
            if (r < 3)       pid = 0;
            else if (r < 85) pid = pid_pool[$urandom_range(POOL_SIZE - 1)];
            else             pid = $urandom_range(1, 255);
            r = $urandom_range(99);
            if (op == OP_COMPLETE) pages = $urandom_range(1, 64);
            else if (r < 4)        pages = 0;
            else if (r < 80)       pages = $urandom_range(1, (frames < 6) ? 1 : frames / 3);
            else if (r < 92)       pages = $urandom_range(1, frames);
            else                   pages = $urandom_range(1, 64);
            queue_request(op, pid, pages);
            // sometimes let everything come back before going on
            if ((n % CHUNK_ITEMS) == CHUNK_ITEMS - 1 && $urandom_range(1) == 1)
                wait_drained();
        end
    endtask

    // sequencer
    initial begin
        clear_allocator(7'd64);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // hand-picked transactions at the reset frame count
        queue_request(OP_ARRIVE,   1,   64);
        queue_request(OP_ARRIVE,   2,   1);
        queue_request(OP_COMPLETE, 0,   1);
        queue_request(OP_ARRIVE,   0,   5);
        queue_request(OP_COMPLETE, 1,   1);
        queue_request(OP_ARRIVE,   255, 0);
        queue_request(OP_ARRIVE,   3,   63);
        // fill the wait queue behind a blocked head, with a duplicate id
        foreach (pid_pool[i]) pid_pool[i] = '0;
        queue_request(OP_ARRIVE, 128, 4);
        queue_request(OP_ARRIVE, 64,  4);
        queue_request(OP_ARRIVE, 32,  4);
        queue_request(OP_ARRIVE, 16,  4);
        queue_request(OP_ARRIVE, 8,   4);
        queue_request(OP_ARRIVE, 4,   4);
        queue_request(OP_ARRIVE, 2,   4);
        queue_request(OP_ARRIVE, 170, 4);
        queue_request(OP_ARRIVE, 85,  4);
        queue_request(OP_ARRIVE, 170, 4);
        queue_request(OP_ARRIVE, 200, 4);
        queue_request(OP_ARRIVE, 100, 4);
        queue_request(OP_ARRIVE, 50,  4);
        queue_request(OP_ARRIVE, 25,  4);
        queue_request(OP_ARRIVE, 12,  4);
        queue_request(OP_ARRIVE, 6,   4);
        queue_request(OP_ARRIVE,   9,   1);
        queue_request(OP_COMPLETE, 85,  1);
        queue_request(OP_COMPLETE, 3,   1);
        queue_request(OP_ARRIVE,   0,   0);
        queue_request(OP_COMPLETE, 170, 1);
        wait_idle();

        // frame table of one frame
        set_frame_count(1);
        run_random(50, 1);
        wait_idle();

        // idle pattern swapped, full frame table
        send_idle_pct = 63;
        recv_idle_pct = 31;
        set_frame_count(64);
        run_random(80, 64);
        wait_idle();

        // no idling, long output hold-off to back the block up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_frame_count(23);
        hold_off_go <= 1'b1;
        run_random(70, 23);
        wait_idle();

        set_frame_count($urandom_range(2, 63));
        run_random(50, frames_managed);
        wait_idle();

        if (failures == 0 && frame_events_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial begin
        #(64'd30_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
sv/pfa_pkg.sv
sv/pfa_front.sv
sv/pfa_cmd_queue.sv
sv/pfa_back.sv
sv/paged_frame_allocator_fifo_unit.sv
sv/pfa_checker.sv
dv/paged_frame_allocator_fifo_unit_tb.sv
